FILE: hdl/lmps_pkg.sv
package lmps_pkg;

  // Panel geometry and color depth
  localparam int ROWS           = 16;
  localparam int COLUMNS        = 32;
  localparam int COMPONENT_BITS = 8;

  localparam int STORE_DEPTH = 2 * ROWS * COLUMNS;
  localparam int PAIRS       = ROWS * COLUMNS;
  localparam int PAIR_W      = $clog2(PAIRS);
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Fixed field widths
  localparam int PIX_W    = 10;
  localparam int CHAN_W   = 8;
  localparam int CYCLE_W  = 8;
  localparam int LEVEL_W  = 9;
  localparam int ROWNUM_W = 4;
  localparam int RGB_W    = 3;
  localparam int PIXEL_W  = 3 * CHAN_W;

  localparam logic [CHAN_W-1:0]  COMP_MASK    = CHAN_W'((1 << COMPONENT_BITS) - 1);
  localparam logic [LEVEL_W-1:0] LEVELS_RESET = LEVEL_W'(256);
  localparam logic [LEVEL_W-1:0] LEVELS_MAX   = LEVEL_W'(256);

  // Command queue depth
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Word kind carried in tuser
  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_TICK  = 1'b1
  } mode_t;

  // One classified command: pixel write or scan tick
  typedef struct packed {
    mode_t                mode;
    logic                 store;      // write address lies inside the store
    logic [PIX_W-1:0]     addr;       // pixel address, or pair index on a tick
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    logic [CYCLE_W-1:0]   cycle;
    logic [ROWNUM_W-1:0]  row;
    logic                 frame_end;
  } cmd_t;

  // Queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Lit bits of one pixel against a PWM cycle
  function automatic logic [RGB_W-1:0] lit_bits(input logic [PIXEL_W-1:0] pix,
                                                input logic [CYCLE_W-1:0] cycle);
    logic [RGB_W-1:0] v;
    v[0] = pix[CHAN_W-1:0] > cycle;
    v[1] = pix[2*CHAN_W-1:CHAN_W] > cycle;
    v[2] = pix[3*CHAN_W-1:2*CHAN_W] > cycle;
    return v;
  endfunction

endpackage

FILE: hdl/led_matrix_pwm_scan_core.sv
// Channel   Dir  Fields (low bit up)                                  Accept
// s_axis    in   tuser: mode; tdata: pixel_index, red, green, blue    tvalid & tready
// m_axis    out  tdata: row_number, first_rgb, second_rgb; tlast:     tvalid & tready
//                frame_end
// cfg       in   cfg_wdata: pwm_levels                                cfg_we
//
// One word per cycle sustained while m_axis does not stall. A tick word reaches m_axis
// through the queue, frame store read and PWM compare; a pixel write produces no output.
// The frame store has one write and one read per bank, split into even and odd pixels,
// so a tick reads both pixels of its pair in one cycle.
// rst is synchronous; the frame store is not cleared and needs loading before use.
// s_axis_tready drops only when the four-entry queue is full; a stall on m_axis
// backs up through the read stage into the queue.
module led_matrix_pwm_scan_core import lmps_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // pixel_index[9:0], red[17:10], green[25:18], blue[33:26]
  input  logic [0:0]   s_axis_tuser,   // mode[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,   // row_number[3:0], first_rgb[6:4], second_rgb[9:7]
  output logic         m_axis_tlast,   // frame_end
  input  logic         cfg_we,
  input  logic [8:0]   cfg_wdata       // pwm_levels
);

  logic    accept;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    head;
  q_stat_t stat;

  logic [ROWNUM_W-1:0] out_row;
  logic [RGB_W-1:0]    out_first;
  logic [RGB_W-1:0]    out_second;

  assign s_axis_tready = !stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lmps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .mode_in     (s_axis_tuser[0]),
    .pixel_index (s_axis_tdata[9:0]),
    .red         (s_axis_tdata[17:10]),
    .green       (s_axis_tdata[25:18]),
    .blue        (s_axis_tdata[33:26]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  lmps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  lmps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .stat       (stat),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_row    (out_row),
    .out_first  (out_first),
    .out_second (out_second),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_second, out_first, out_row};

endmodule

FILE: hdl/lmps_front.sv
module lmps_front import lmps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                mode_in,
  input  logic [PIX_W-1:0]    pixel_index,
  input  logic [CHAN_W-1:0]   red,
  input  logic [CHAN_W-1:0]   green,
  input  logic [CHAN_W-1:0]   blue,
  input  logic                cfg_we,
  input  logic [LEVEL_W-1:0]  cfg_wdata,
  output logic                push,
  output cmd_t                push_cmd
);

  logic [LEVEL_W-1:0] levels;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [CYCLE_W-1:0] cycle;
  logic [PAIR_W-1:0]  pair;

  logic [LEVEL_W-1:0] last_level;
  logic               last_col;
  logic               last_row;
  logic               last_cycle;
  logic               is_tick;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= LEVELS_RESET;
    end else if (cfg_we) begin
      levels <= cfg_wdata;
    end
  end

  // Clamp levels to 1..256 and find the last cycle
  always_comb begin
    if (levels == '0) begin
      last_level = '0;
    end else if (levels > LEVELS_MAX) begin
      last_level = LEVELS_MAX - LEVEL_W'(1);
    end else begin
      last_level = levels - LEVEL_W'(1);
    end
  end

  assign is_tick    = mode_in == MODE_TICK;
  assign last_col   = col >= COL_W'(COLUMNS - 1);
  assign last_row   = row >= ROW_W'(ROWS - 1);
  assign last_cycle = {1'b0, cycle} >= last_level;

  // Classify the word
  always_comb begin
    push               = accept;
    push_cmd.mode      = is_tick ? MODE_TICK : MODE_WRITE;
    push_cmd.store     = {1'b0, pixel_index} < (PIX_W + 1)'(STORE_DEPTH);
    push_cmd.addr      = is_tick ? PIX_W'(pair) : pixel_index;
    push_cmd.red       = red & COMP_MASK;
    push_cmd.green     = green & COMP_MASK;
    push_cmd.blue      = blue & COMP_MASK;
    push_cmd.cycle     = cycle;
    push_cmd.row       = ROWNUM_W'(row);
    push_cmd.frame_end = last_col && last_row && last_cycle;
  end

  // Scan counters: column, then row, then PWM cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      cycle <= '0;
      pair  <= '0;
    end else if (accept && is_tick) begin
      if (!last_col) begin
        col  <= col + COL_W'(1);
        pair <= pair + PAIR_W'(1);
      end else begin
        col <= '0;
        if (!last_row) begin
          row  <= row + ROW_W'(1);
          pair <= pair + PAIR_W'(1);
        end else begin
          row  <= '0;
          pair <= '0;
          if (last_cycle) begin
            cycle <= '0;
          end else begin
            cycle <= cycle + CYCLE_W'(1);
          end
        end
      end
    end
  end

endmodule

FILE: hdl/lmps_queue.sv
module lmps_queue import lmps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign stat.full  = count == QCNT_W'(QDEPTH);
  assign stat.empty = count == '0;
  assign head       = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/lmps_back.sv
module lmps_back import lmps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                head,
  input  q_stat_t             stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ROWNUM_W-1:0] out_row,
  output logic [RGB_W-1:0]    out_first,
  output logic [RGB_W-1:0]    out_second,
  output logic                out_last
);

  // Frame store split into even and odd pixel banks
  logic [PIXEL_W-1:0] bank_even [PAIRS];
  logic [PIXEL_W-1:0] bank_odd  [PAIRS];

  logic                s1_valid;
  logic [CYCLE_W-1:0]  s1_cycle;
  logic [ROWNUM_W-1:0] s1_row;
  logic                s1_last;
  logic [PIXEL_W-1:0]  rd_even;
  logic [PIXEL_W-1:0]  rd_odd;

  logic out_free;
  logic s1_free;
  logic pop_tick;
  logic pop_write;
  logic [PAIR_W-1:0] wr_pair;
  logic [PAIR_W-1:0] rd_pair;

  assign out_free  = !out_valid || out_ready;
  assign s1_free   = !s1_valid || out_free;
  assign pop       = !stat.empty && (head.mode == MODE_WRITE || s1_free);
  assign pop_tick  = pop && head.mode == MODE_TICK;
  assign pop_write = pop && head.mode == MODE_WRITE && head.store;
  assign wr_pair   = head.addr[PAIR_W:1];
  assign rd_pair   = head.addr[PAIR_W-1:0];

  // Pixel writes
  always_ff @(posedge clk) begin
    if (pop_write) begin
      if (head.addr[0]) begin
        bank_odd[wr_pair] <= {head.blue, head.green, head.red};
      end else begin
        bank_even[wr_pair] <= {head.blue, head.green, head.red};
      end
    end
  end

  // Read stage: both pixels of the pair
  always_ff @(posedge clk) begin
    if (pop_tick) begin
      rd_even  <= bank_even[rd_pair];
      rd_odd   <= bank_odd[rd_pair];
      s1_cycle <= head.cycle;
      s1_row   <= head.row;
      s1_last  <= head.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= pop_tick;
    end
  end

  // Output register: PWM compare
  always_ff @(posedge clk) begin
    if (s1_valid && out_free) begin
      out_row    <= s1_row;
      out_first  <= lit_bits(rd_even, s1_cycle);
      out_second <= lit_bits(rd_odd, s1_cycle);
      out_last   <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

endmodule

FILE: hdl/lmps_checker.sv
module lmps_checker import lmps_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Queue is empty right after reset
  a_ready_after_rst: assert property (@(posedge clk) $past(rst) |-> s_axis_tready)
    else $error("s_axis_tready low after reset");

  // No output word right after reset
  a_idle_after_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("m_axis_tvalid high after reset");

  // Frame end only on the last scan row
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[ROWNUM_W-1:0] == ROWNUM_W'(ROWS - 1))
    else $error("frame end flagged off the last row");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

endmodule

bind led_matrix_pwm_scan_core lmps_checker u_lmps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
